>>> design/dq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue: operation codes, error
// codes, control states and the result flags passed from control to top.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        FUNC_PUSH_BACK  = 2'd0,
        FUNC_PUSH_FRONT = 2'd1,
        FUNC_POP_FRONT  = 2'd2,
        FUNC_POP_BACK   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } t_err;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_RESULT = 1'b1
    } t_state;

    // Flags of one result beat, settled at accept time.
    typedef struct packed {
        t_err err;
        logic is_empty;
        logic use_ram;   // end value comes from the memory read
        logic end_zero;  // end value is zero (queue empty afterwards)
    } t_res;

endpackage

`default_nettype wire

>>> design/double_ended_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue kept in a ring buffer memory.
//
//   Channel   Handshake                 Payload
//   -------   -----------------------   ---------------------------------
//   command   start / busy              i_func, i_value
//   result    o_valid (one-cycle)       o_end_value, o_is_empty, o_error
//
// For each command the accept cycle issues any memory write or read, and the
// result beat follows in the next cycle with the registered read data of
// the ring memory. busy is high during the result cycle, so no new command
// is taken until the result beat has been given. Synchronous reset empties
// the queue at once; no clearing pass runs. The result cannot be stalled.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           i_func,
    input  wire logic signed [31:0]   i_value,
    output logic                      o_valid,
    output logic signed [31:0]        o_end_value,
    output logic                      o_is_empty,
    output logic [1:0]                o_error
);

    localparam int AW = $clog2(DEPTH);

    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic [dq_pkg::DATA_W-1:0]     rd_data;
    dq_pkg::t_res                  res;
    logic [dq_pkg::DATA_W-1:0]     r_push_value;

    dq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_func    (i_func),
        .o_busy    (busy),
        .o_valid   (o_valid),
        .o_res     (res),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr)
    );

    dq_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Hold the pushed value: a successful push reports it directly.
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_push_value <= i_value;
        end
    end

    always_comb begin
        if (res.end_zero) begin
            o_end_value = '0;
        end else if (res.use_ram) begin
            o_end_value = rd_data;
        end else begin
            o_end_value = r_push_value;
        end
    end

    assign o_is_empty = res.is_empty;
    assign o_error    = res.err;

endmodule

`default_nettype wire

>>> design/dq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ram
// Ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]         i_wr_addr,
    input  wire logic [dq_pkg::DATA_W-1:0]        i_wr_data,
    input  wire logic                             i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]         i_rd_addr,
    output logic      [dq_pkg::DATA_W-1:0]        o_rd_data
);

    logic [dq_pkg::DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> design/dq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ctrl
// Head and count registers, slot arithmetic and the two-state sequencer that
// issues the memory write or read that each operation needs.
// ----------------------------------------------------------------------------
module dq_ctrl #(
    parameter int DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [1:0]                 i_func,
    output logic                            o_busy,
    output logic                            o_valid,
    output dq_pkg::t_res                    o_res,
    output logic                            o_wr_en,
    output logic [$clog2(DEPTH)-1:0]        o_wr_addr,
    output logic                            o_rd_en,
    output logic [$clog2(DEPTH)-1:0]        o_rd_addr
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    dq_pkg::t_state r_state, n_state;
    logic [AW-1:0]  r_head, n_head;
    logic [CW-1:0]  r_count, n_count;
    dq_pkg::t_res   r_res, n_res;

    logic           accept;
    logic           full;
    logic           empty;
    logic [AW-1:0]  head_m1;
    logic [AW-1:0]  head_p1;
    logic [AW-1:0]  tail_slot;
    logic [AW-1:0]  back_slot;
    logic [AW-1:0]  back_m1_slot;

    // Head plus an offset of at most DEPTH, folded back into the ring.
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(off);
        if (s >= DEPTH_S) begin
            s = s - DEPTH_S;
        end
        return s[AW-1:0];
    endfunction

    assign accept       = i_start && (r_state == dq_pkg::ST_IDLE);
    assign full         = (r_count == DEPTH_C);
    assign empty        = (r_count == '0);
    assign head_m1      = (r_head == '0) ? LAST_SLOT : r_head - AW'(1);
    assign head_p1      = (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);
    assign tail_slot    = slot_of(r_head, r_count);
    assign back_slot    = slot_of(r_head, r_count - CW'(1));
    assign back_m1_slot = slot_of(r_head, r_count - CW'(2));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dq_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = dq_pkg::ST_RESULT;
                end
            end
            dq_pkg::ST_RESULT: n_state = dq_pkg::ST_IDLE;
            default:           n_state = dq_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_busy  = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            dq_pkg::ST_IDLE:   o_busy = 1'b0;
            dq_pkg::ST_RESULT: begin
                o_busy  = 1'b1;
                o_valid = 1'b1;
            end
            default: begin
                o_busy  = 1'b0;
                o_valid = 1'b0;
            end
        endcase
    end

    // Pointer update and memory access for the accepted operation
    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_res      = r_res;
        o_wr_en    = 1'b0;
        o_wr_addr  = tail_slot;
        o_rd_en    = 1'b0;
        o_rd_addr  = back_slot;
        if (accept) begin
            n_res.err      = dq_pkg::ERR_OK;
            n_res.use_ram  = 1'b0;
            n_res.end_zero = 1'b0;
            case (dq_pkg::t_func'(i_func))
                dq_pkg::FUNC_PUSH_BACK: begin
                    if (full) begin
                        n_res.err     = dq_pkg::ERR_FULL;
                        n_res.use_ram = 1'b1;
                        o_rd_en       = 1'b1;
                        o_rd_addr     = back_slot;
                    end else begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = tail_slot;
                        n_count   = r_count + CW'(1);
                    end
                end
                dq_pkg::FUNC_PUSH_FRONT: begin
                    if (full) begin
                        n_res.err     = dq_pkg::ERR_FULL;
                        n_res.use_ram = 1'b1;
                        o_rd_en       = 1'b1;
                        o_rd_addr     = r_head;
                    end else begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = head_m1;
                        n_head    = head_m1;
                        n_count   = r_count + CW'(1);
                    end
                end
                dq_pkg::FUNC_POP_FRONT: begin
                    if (empty) begin
                        n_res.err      = dq_pkg::ERR_EMPTY;
                        n_res.end_zero = 1'b1;
                    end else begin
                        n_head    = head_p1;
                        n_count   = r_count - CW'(1);
                        o_rd_en   = 1'b1;
                        o_rd_addr = head_p1;
                        if (r_count == CW'(1)) begin
                            n_res.end_zero = 1'b1;
                        end else begin
                            n_res.use_ram = 1'b1;
                        end
                    end
                end
                dq_pkg::FUNC_POP_BACK: begin
                    if (empty) begin
                        n_res.err      = dq_pkg::ERR_EMPTY;
                        n_res.end_zero = 1'b1;
                    end else begin
                        n_count   = r_count - CW'(1);
                        o_rd_en   = 1'b1;
                        o_rd_addr = back_m1_slot;
                        if (r_count == CW'(1)) begin
                            n_res.end_zero = 1'b1;
                        end else begin
                            n_res.use_ram = 1'b1;
                        end
                    end
                end
                default: n_res.err = dq_pkg::ERR_OK;
            endcase
            n_res.is_empty = (n_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dq_pkg::ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

>>> tb/sv/double_ended_queue_tb.sv
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the ring-buffer deque. A directed table covers
// empty pops, extreme values, front wrap, a full fill and pushes on full.
// Random bursts follow: fill-heavy, drain-heavy or uniform. Every result
// beat is checked against its typed expectation or an in-bench deque model.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;

    localparam int  SLOTS      = 16;
    localparam int  RAND_BEATS = 1250;
    localparam int  CYCLE_CAP  = 200000;
    localparam int  DRAIN_WAIT = 8;

    typedef struct {
        logic signed [31:0] end_value;
        logic               is_empty;
        dq_pkg::t_err       err;
    } t_deque_result;

    typedef struct {
        dq_pkg::t_func      func;
        logic signed [31:0] value;
        bit                 typed;   // expectation typed in below
        t_deque_result      want;
    } t_plan_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_func;
    logic signed [31:0] i_value;
    logic               o_valid;
    logic signed [31:0] o_end_value;
    logic               o_is_empty;
    logic [1:0]         o_error;

    // deque model state
    logic signed [31:0] ring_slots [SLOTS];
    logic [3:0]         ring_head;
    logic [4:0]         ring_count;

    t_deque_result      pending_results [$];
    t_plan_row          plan [$];
    int                 mismatches;
    int                 cycles;

    double_ended_queue #(.DEPTH(SLOTS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_func      (i_func),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_end_value (o_end_value),
        .o_is_empty  (o_is_empty),
        .o_error     (o_error)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic signed [31:0] front_entry();
        return (ring_count != 0) ? ring_slots[ring_head] : 32'sd0;
    endfunction

    function automatic logic signed [31:0] back_entry();
        logic [3:0] idx;
        idx = ring_head + ring_count[3:0] - 4'd1;
        return (ring_count != 0) ? ring_slots[idx] : 32'sd0;
    endfunction

    function automatic t_deque_result deque_apply(dq_pkg::t_func f, logic signed [31:0] v);
        t_deque_result r;
        logic [3:0]    idx;
        r.err = dq_pkg::ERR_OK;
        case (f)
            dq_pkg::FUNC_PUSH_BACK: begin
                if (ring_count == 5'(SLOTS)) begin
                    r.err = dq_pkg::ERR_FULL;
                end else begin
                    idx = ring_head + ring_count[3:0];
                    ring_slots[idx] = v;
                    ring_count++;
                end
                r.end_value = back_entry();
            end
            dq_pkg::FUNC_PUSH_FRONT: begin
                if (ring_count == 5'(SLOTS)) begin
                    r.err = dq_pkg::ERR_FULL;
                end else begin
                    ring_head = ring_head - 4'd1;
                    ring_slots[ring_head] = v;
                    ring_count++;
                end
                r.end_value = front_entry();
            end
            dq_pkg::FUNC_POP_FRONT: begin
                if (ring_count == 0) begin
                    r.err = dq_pkg::ERR_EMPTY;
                end else begin
                    ring_head = ring_head + 4'd1;
                    ring_count--;
                end
                r.end_value = front_entry();
            end
            default: begin
                if (ring_count == 0) begin
                    r.err = dq_pkg::ERR_EMPTY;
                end else begin
                    ring_count--;
                end
                r.end_value = back_entry();
            end
        endcase
        r.is_empty = (ring_count == 0);
        return r;
    endfunction

    function automatic void add_row(dq_pkg::t_func f, logic signed [31:0] v, bit typed,
                                    logic signed [31:0] end_v, logic empty,
                                    dq_pkg::t_err err);
        t_plan_row row;
        row.func           = f;
        row.value          = v;
        row.typed          = typed;
        row.want.end_value = end_v;
        row.want.is_empty  = empty;
        row.want.err       = err;
        plan.insert(plan.size(), row);
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0d, expected %0d", cycles, field, got, want);
        mismatches++;
    endtask

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(dq_pkg::t_func f, logic signed [31:0] v, int gap,
                             bit typed, t_deque_result want);
        t_deque_result predicted;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start   <= 1'b1;
        i_func  <= f;
        i_value <= v;
        do @(posedge i_clk); while (busy);
        predicted = deque_apply(f, v);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
        @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_deque_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (o_end_value !== want.end_value)
                    report_mismatch("end_value", o_end_value, want.end_value);
                if (o_is_empty !== want.is_empty)
                    report_mismatch("is_empty", o_is_empty, want.is_empty);
                if (o_error !== want.err)
                    report_mismatch("error", o_error, want.err);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout at cycle %0d", cycles);
            $display("double_ended_queue_tb: FAIL");
            $finish;
        end
    end

    initial begin
        t_deque_result none;
        int            sent;
        int            burst_len;
        int            mode;
        bit            idle_on;
        int            gap;
        dq_pkg::t_func f;

        start      = 1'b0;
        i_func     = dq_pkg::FUNC_PUSH_BACK;
        i_value    = '0;
        i_rst_n    = 1'b0;
        ring_head  = '0;
        ring_count = '0;
        mismatches = 0;
        cycles     = 0;
        none       = '{end_value: 32'sd0, is_empty: 1'b1, err: dq_pkg::ERR_OK};
        foreach (ring_slots[k]) ring_slots[k] = '0;

        // empty pops, extremes, front wrap from slot zero
        add_row(dq_pkg::FUNC_POP_FRONT,  32'sd0, 1, 32'sd0, 1'b1, dq_pkg::ERR_EMPTY);
        add_row(dq_pkg::FUNC_POP_BACK,   32'sd0, 1, 32'sd0, 1'b1, dq_pkg::ERR_EMPTY);
        add_row(dq_pkg::FUNC_PUSH_BACK,  32'sh7fff_ffff, 1, 32'sh7fff_ffff, 1'b0,
                dq_pkg::ERR_OK);
        add_row(dq_pkg::FUNC_PUSH_FRONT, 32'sh8000_0000, 1, 32'sh8000_0000, 1'b0,
                dq_pkg::ERR_OK);
        add_row(dq_pkg::FUNC_POP_BACK,   32'sd0, 1, 32'sh8000_0000, 1'b0, dq_pkg::ERR_OK);
        add_row(dq_pkg::FUNC_POP_FRONT,  32'sd0, 1, 32'sd0, 1'b1, dq_pkg::ERR_OK);
        // fill from both ends, then push on full at each end
        for (int k = 0; k < SLOTS; k++)
            add_row((k % 2) ? dq_pkg::FUNC_PUSH_FRONT : dq_pkg::FUNC_PUSH_BACK,
                    32'sh0101_0101 * (k + 1), 0, 32'sd0, 1'b0, dq_pkg::ERR_OK);
        add_row(dq_pkg::FUNC_PUSH_BACK,  32'sd5, 0, 32'sd0, 1'b0, dq_pkg::ERR_FULL);
        add_row(dq_pkg::FUNC_PUSH_FRONT, -32'sd5, 0, 32'sd0, 1'b0, dq_pkg::ERR_FULL);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[k])
            send_beat(plan[k].func, plan[k].value, $urandom_range(0, 14),
                      plan[k].typed, plan[k].want);

        // bursts: fill-heavy, drain-heavy or uniform, with or without idling
        sent = 0;
        while (sent < RAND_BEATS) begin
            burst_len = $urandom_range(4, 40);
            mode      = $urandom_range(0, 2);
            idle_on   = ($urandom_range(0, 2) != 0);
            repeat (burst_len) begin
                case (mode)
                    0: f = ($urandom_range(0, 9) < 8) ? dq_pkg::t_func'($urandom_range(0, 1))
                                                      : dq_pkg::t_func'($urandom_range(2, 3));
                    1: f = ($urandom_range(0, 9) < 8) ? dq_pkg::t_func'($urandom_range(2, 3))
                                                      : dq_pkg::t_func'($urandom_range(0, 1));
                    default: f = dq_pkg::t_func'($urandom_range(0, 3));
                endcase
                gap = idle_on ? $urandom_range(0, 14) : 0;
                send_beat(f, pick_value(), gap, 0, none);
                sent++;
            end
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0)
            $display("double_ended_queue_tb: PASS");
        else
            $display("double_ended_queue_tb: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
design/dq_pkg.sv
design/dq_ram.sv
design/dq_ctrl.sv
design/double_ended_queue.sv
tb/sv/double_ended_queue_tb.sv
